// ----- rtl/nfba_pkg.sv -----
`timescale 1ns / 1ps

package nfba_pkg;

  // fixed field widths
  localparam int IdW   = 10;
  localparam int CmdW  = 2;
  localparam int StatW = 2;

  // defaults for the top-level parameters
  localparam int DefMaxIds   = 1024;
  localparam int DefWordBits = 32;

  // reciprocal division of an id by the word size: q = (id * recip) >> DivShift
  localparam int DivShift = 18;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CHECK   = 2'd2
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_FIRST,
    S_SCAN,
    S_LOOKUP,
    S_MODIFY,
    S_DONE
  } nfba_state_e;

  typedef struct packed {
    status_e          status;
    logic [IdW-1:0]   new_id;
    logic             alive;
  } nfba_result_t;

endpackage

// ----- rtl/next_fit_bitmap_id_allocator.sv -----
`timescale 1ns / 1ps

// next-fit id allocator over a bitmap of used ids held in a one-port-read,
// one-port-write word memory (one word per cycle).
// input channel: in_valid_i / in_stall_o with command_i and id_value_i;
//   allocate hands out the lowest free id at or after one past the last
//   issued id (wrapping to id one), release frees a used id, check reports
//   whether an id is in use. id zero is never issued.
// output channel: out_valid_o / out_stall_i with status_o, new_id_o, alive_o;
//   exactly one result transaction per input transaction, in order.
// timing: for release and check the transaction passes through lookup, modify
//   and done, and for an allocate whose first word holds a free id through
//   start, first and done; from done the result moves to the output register.
//   an allocate scans one further bitmap word at a time (up to NUM_WORDS more),
//   with one memory read per word. one transaction is in flight at a time;
//   a new one is taken once the result has moved to the output register.
// reset: the bitmap is cleared by a pass over all NUM_WORDS words, one word per
//   cycle, during which in_stall_o stays high; last issued id resets to zero.
// stall: a stalled result holds in the output register; one further
//   transaction may be accepted and worked on, and waits for the register.

module next_fit_bitmap_id_allocator
  import nfba_pkg::*;
#(
  parameter int MAX_IDS   = DefMaxIds,
  parameter int WORD_BITS = DefWordBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CmdW-1:0]   command_i,
  input  logic [IdW-1:0]    id_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [StatW-1:0]  status_o,
  output logic [IdW-1:0]    new_id_o,
  output logic              alive_o
);

  localparam int NumWords = (MAX_IDS - 1) / WORD_BITS + 1;
  localparam int WI       = (NumWords > 1) ? $clog2(NumWords) : 1;

  logic                 done;
  logic                 out_free;
  nfba_result_t         result;
  logic                 mem_re;
  logic [WI-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;
  logic                 mem_we;
  logic [WI-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic                 out_valid_q, out_valid_d;
  nfba_result_t         out_res_q;

  // bitmap store, one word per entry
  nfba_mem #(
    .DEPTH (NumWords),
    .WIDTH (WORD_BITS),
    .AW    (WI)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // sequencer: clearing pass, scan and read-modify-write of the bitmap
  nfba_ctrl #(
    .NUM_WORDS (NumWords),
    .WORD_BITS (WORD_BITS),
    .WI        (WI)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (command_i),
    .id_i        (id_value_i),
    .out_free_i  (out_free),
    .done_o      (done),
    .result_o    (result),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  // output register frees up when empty or when its transaction is taken
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_res_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_res_q.status;
  assign new_id_o    = out_res_q.new_id;
  assign alive_o     = out_res_q.alive;

endmodule

// ----- rtl/nfba_mem.sv -----
`timescale 1ns / 1ps

module nfba_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/nfba_pick.sv -----
`timescale 1ns / 1ps

module nfba_pick #(
  parameter int WORD_BITS = 32,
  parameter int BI        = 5
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic                 word_zero_i,
  input  logic                 lo_en_i,
  input  logic [BI-1:0]        lo_bit_i,
  output logic                 found_o,
  output logic [BI-1:0]        bit_o
);

  logic [WORD_BITS-1:0] free;

  // bits below the start point and id zero count as taken
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      free[i] = ~word_i[i];
      if (lo_en_i && (i < int'(lo_bit_i))) begin
        free[i] = 1'b0;
      end
    end
    if (word_zero_i) begin
      free[0] = 1'b0;
    end
  end

  // lowest free bit
  always_comb begin
    bit_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free[i]) begin
        bit_o = BI'(i);
      end
    end
  end

  assign found_o = |free;

endmodule

// ----- rtl/nfba_ctrl.sv -----
`timescale 1ns / 1ps

module nfba_ctrl
  import nfba_pkg::*;
#(
  parameter int NUM_WORDS = 32,
  parameter int WORD_BITS = 32,
  parameter int WI        = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CmdW-1:0]      cmd_i,
  input  logic [IdW-1:0]       id_i,
  input  logic                 out_free_i,
  output logic                 done_o,
  output nfba_result_t         result_o,
  output logic                 mem_re_o,
  output logic [WI-1:0]        mem_raddr_o,
  input  logic [WORD_BITS-1:0] mem_rdata_i,
  output logic                 mem_we_o,
  output logic [WI-1:0]        mem_waddr_o,
  output logic [WORD_BITS-1:0] mem_wdata_o
);

  localparam int BI      = $clog2(WORD_BITS);
  localparam int IdLimit = NUM_WORDS * WORD_BITS;
  localparam int Recip   = (1 << DivShift) / WORD_BITS + 1;
  localparam int ProdW   = IdW + DivShift;
  localparam int FullW   = WI + BI + 1;

  nfba_state_e state_q, state_d;

  logic [WI-1:0]  clr_cnt_q, clr_cnt_d;
  logic [WI-1:0]  last_w_q, last_w_d;
  logic [BI-1:0]  last_b_q, last_b_d;

  logic [CmdW-1:0] cmd_q, cmd_d;
  logic [IdW-1:0]  id_q, id_d;
  logic [IdW-1:0]  quo_q, quo_d;
  logic [WI-1:0]   cur_w_q, cur_w_d;
  logic [BI-1:0]   bit_q, bit_d;
  logic [WI-1:0]   scan_cnt_q, scan_cnt_d;
  logic            range_ok_q, range_ok_d;
  status_e         res_status_q, res_status_d;
  logic [WI-1:0]   res_w_q, res_w_d;
  logic [BI-1:0]   res_b_q, res_b_d;
  logic            res_alive_q, res_alive_d;
  logic            res_ok_q, res_ok_d;

  logic [ProdW-1:0] prod;
  logic [IdW-1:0]   rem_full;
  logic [WI-1:0]    next_w;
  logic [WI-1:0]    start_w;
  logic [BI-1:0]    start_b;
  logic             pick_found;
  logic [BI-1:0]    pick_bit;
  logic             id_used;
  logic [FullW-1:0] new_id_full;

  nfba_pick #(
    .WORD_BITS (WORD_BITS),
    .BI        (BI)
  ) u_pick (
    .word_i      (mem_rdata_i),
    .word_zero_i (cur_w_q == '0),
    .lo_en_i     (state_q == S_FIRST),
    .lo_bit_i    (bit_q),
    .found_o     (pick_found),
    .bit_o       (pick_bit)
  );

  assign prod     = ProdW'(id_i) * ProdW'(Recip);
  assign rem_full = id_q - IdW'(quo_q * IdW'(WORD_BITS));
  assign next_w   = (cur_w_q == WI'(NUM_WORDS - 1)) ? '0 : cur_w_q + 1'b1;
  assign id_used  = range_ok_q && mem_rdata_i[bit_q];

  // one past the last issued id, wrapping to id one
  always_comb begin
    start_w = last_w_q;
    start_b = last_b_q + 1'b1;
    if (last_b_q == BI'(WORD_BITS - 1)) begin
      if (last_w_q == WI'(NUM_WORDS - 1)) begin
        start_w = '0;
        start_b = BI'(1);
      end else begin
        start_w = last_w_q + 1'b1;
        start_b = '0;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    last_w_d     = last_w_q;
    last_b_d     = last_b_q;
    cmd_d        = cmd_q;
    id_d         = id_q;
    quo_d        = quo_q;
    cur_w_d      = cur_w_q;
    bit_d        = bit_q;
    scan_cnt_d   = scan_cnt_q;
    range_ok_d   = range_ok_q;
    res_status_d = res_status_q;
    res_w_d      = res_w_q;
    res_b_d      = res_b_q;
    res_alive_d  = res_alive_q;
    res_ok_d     = res_ok_q;
    in_stall_o   = 1'b1;
    done_o       = 1'b0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = cur_w_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = cur_w_q;
    mem_wdata_o  = mem_rdata_i | (WORD_BITS'(1) << pick_bit);

    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_cnt_q;
        mem_wdata_o = '0;
        clr_cnt_d   = clr_cnt_q + 1'b1;
        if (clr_cnt_q == WI'(NUM_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_d        = cmd_i;
          id_d         = id_i;
          quo_d        = prod[DivShift +: IdW];
          res_status_d = ST_OK;
          res_alive_d  = 1'b0;
          res_ok_d     = 1'b0;
          case (cmd_e'(cmd_i))
            CMD_ALLOC:   state_d = S_START;
            CMD_RELEASE: state_d = S_LOOKUP;
            CMD_CHECK:   state_d = S_LOOKUP;
            default: begin
              res_status_d = ST_INVALID;
              state_d      = S_DONE;
            end
          endcase
        end
      end
      S_START: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = start_w;
        cur_w_d     = start_w;
        bit_d       = start_b;
        state_d     = S_FIRST;
      end
      S_FIRST, S_SCAN: begin
        if (pick_found) begin
          mem_we_o     = 1'b1;
          last_w_d     = cur_w_q;
          last_b_d     = pick_bit;
          res_w_d      = cur_w_q;
          res_b_d      = pick_bit;
          res_ok_d     = 1'b1;
          state_d      = S_DONE;
        end else if (state_q == S_SCAN && scan_cnt_q == WI'(NUM_WORDS - 1)) begin
          res_status_d = ST_FULL;
          state_d      = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = next_w;
          cur_w_d     = next_w;
          scan_cnt_d  = (state_q == S_FIRST) ? '0 : scan_cnt_q + 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_LOOKUP: begin
        bit_d       = rem_full[BI-1:0];
        range_ok_d  = (id_q != '0) && (32'(id_q) < 32'(IdLimit));
        mem_re_o    = 1'b1;
        mem_raddr_o = WI'(quo_q);
        cur_w_d     = WI'(quo_q);
        state_d     = S_MODIFY;
      end
      S_MODIFY: begin
        mem_wdata_o = mem_rdata_i & ~(WORD_BITS'(1) << bit_q);
        if (cmd_e'(cmd_q) == CMD_RELEASE) begin
          if (id_used) begin
            mem_we_o = 1'b1;
          end else begin
            res_status_d = ST_INVALID;
          end
        end else begin
          res_alive_d = id_used;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      last_w_q  <= '0;
      last_b_q  <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      last_w_q  <= last_w_d;
      last_b_q  <= last_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    id_q         <= id_d;
    quo_q        <= quo_d;
    cur_w_q      <= cur_w_d;
    bit_q        <= bit_d;
    scan_cnt_q   <= scan_cnt_d;
    range_ok_q   <= range_ok_d;
    res_status_q <= res_status_d;
    res_w_q      <= res_w_d;
    res_b_q      <= res_b_d;
    res_alive_q  <= res_alive_d;
    res_ok_q     <= res_ok_d;
  end

  assign new_id_full = FullW'(res_w_q) * FullW'(WORD_BITS) + FullW'(res_b_q);

  assign result_o.status = res_status_q;
  assign result_o.new_id = res_ok_q ? IdW'(new_id_full) : '0;
  assign result_o.alive  = res_alive_q;

  // a word is never read and written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_re_o && mem_we_o))
    else $error("nfba_ctrl: read and write of the bitmap in one cycle");

  // id zero is never issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_ok_q) |-> (res_w_q != '0 || res_b_q != '0))
    else $error("nfba_ctrl: id zero handed out");

  // the clearing pass covers every word before the first transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && $past(state_q) == S_CLEAR) |->
      $past(clr_cnt_q) == WI'(NUM_WORDS - 1))
    else $error("nfba_ctrl: clearing pass left early");

  // a successful allocate records the issued id as the new start point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_ok_q) |-> (last_w_q == res_w_q && last_b_q == res_b_q))
    else $error("nfba_ctrl: last issued id out of step with result");

endmodule
